### design/pjt_pkg.sv
package pjt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KIND_W  = 3;
  localparam int PID_W   = 22;
  localparam int JOB_W   = 16;
  localparam int RST_W   = 2;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 3;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (POS_W + PID_W + JOB_W + RST_W + COUNT_W);

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LK_PID  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LK_JOB  = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ABSENT  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_PRESENT = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd3;

  // Run states.
  localparam logic [RST_W-1:0] RUN_RUNNING = 2'd0;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [JOB_W-1:0] job;
    logic [RST_W-1:0] run_state;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_SHIFT,
    S_DONE
  } seq_state_t;

endpackage

### design/process_job_table.sv
// A request scans the table one entry at a time through the registered read; a miss
// scans every used entry, a hit ends the scan early, and a remove that hits then shifts
// the later entries down. A result still stalled at the output adds its wait.
// One request at a time; in_tready returns with out_tvalid, so the next request is
// taken only once the scan, any shift and the result of the last one are through.
// Reset (rst_n low, synchronous) empties the table and drops any pending result.
module process_job_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // proc_id [21:0], job_number [37:22], new_state [39:38]
  input  logic [pjt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind [2:0]
  input  logic [pjt_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // position [3:0], pid_out [25:4], job_out [41:26], state_out [43:42],
  // entry_count [48:44], zero [55:49]
  output logic [pjt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status [1:0], found [2]
  output logic [pjt_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int IDX_W = pjt_pkg::IDX_W;
  localparam int CNT_W = pjt_pkg::CNT_W;

  pjt_pkg::seq_state_t state_r, state_nxt;

  logic [pjt_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [pjt_pkg::PID_W-1:0]  pid_r, pid_nxt;
  logic [pjt_pkg::JOB_W-1:0]  job_r, job_nxt;
  logic [pjt_pkg::RST_W-1:0]  nst_r, nst_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  pjt_pkg::entry_t  ent_r, ent_nxt;

  logic [pjt_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic                       res_found_r, res_found_nxt;
  logic [pjt_pkg::POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic [pjt_pkg::PID_W-1:0]  res_pid_r, res_pid_nxt;
  logic [pjt_pkg::JOB_W-1:0]  res_job_r, res_job_nxt;
  logic [pjt_pkg::RST_W-1:0]  res_st_r, res_st_nxt;

  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [pjt_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [pjt_pkg::OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // Table memory: one write and one registered read per cycle.
  pjt_pkg::entry_t mem [pjt_pkg::TABLE_DEPTH];
  pjt_pkg::entry_t rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  pjt_pkg::entry_t  wr_data;

  logic key_match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign key_match = chk_vld_r &&
                     ((kind_r == pjt_pkg::KIND_LK_JOB) ? (rd_data_r.job == job_r)
                                                       : (rd_data_r.pid == pid_r));

  assign in_tready  = (state_r == pjt_pkg::S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    pid_nxt        = pid_r;
    job_nxt        = job_r;
    nst_nxt        = nst_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    hit_nxt        = hit_r;
    idx_nxt        = idx_r;
    ent_nxt        = ent_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    res_pid_nxt    = res_pid_r;
    res_job_nxt    = res_job_r;
    res_st_nxt     = res_st_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    rd_addr        = scan_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = ent_r;

    unique case (state_r)
      pjt_pkg::S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt    = in_tuser[2:0];
          pid_nxt     = in_tdata[21:0];
          job_nxt     = in_tdata[37:22];
          nst_nxt     = in_tdata[39:38];
          scan_nxt    = '0;
          chk_vld_nxt = 1'b0;
          hit_nxt     = 1'b0;
          state_nxt   = (in_tuser[2:0] > pjt_pkg::KIND_LK_JOB) ? pjt_pkg::S_FIN
                                                               : pjt_pkg::S_SCAN;
        end
      end

      // Reads stream out one entry a cycle; each is compared the cycle after.
      pjt_pkg::S_SCAN: begin
        if (key_match) begin
          hit_nxt     = 1'b1;
          idx_nxt     = chk_idx_r;
          ent_nxt     = rd_data_r;
          chk_vld_nxt = 1'b0;
          state_nxt   = pjt_pkg::S_FIN;
        end else if (scan_r < count_r) begin
          chk_idx_nxt = scan_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
          scan_nxt    = scan_r + CNT_W'(1);
        end else begin
          chk_vld_nxt = 1'b0;
          state_nxt   = pjt_pkg::S_FIN;
        end
      end

      pjt_pkg::S_FIN: begin
        res_status_nxt = pjt_pkg::STATUS_OK;
        res_found_nxt  = 1'b0;
        res_pos_nxt    = '0;
        res_pid_nxt    = '0;
        res_job_nxt    = '0;
        res_st_nxt     = '0;
        state_nxt      = pjt_pkg::S_DONE;
        unique case (kind_r)
          pjt_pkg::KIND_ADD: begin
            if (hit_r) begin
              res_status_nxt = pjt_pkg::STATUS_PRESENT;
              res_found_nxt  = 1'b1;
              res_pos_nxt    = pjt_pkg::POS_W'(idx_r);
              res_pid_nxt    = ent_r.pid;
              res_job_nxt    = ent_r.job;
              res_st_nxt     = ent_r.run_state;
            end else if (count_r == CNT_W'(pjt_pkg::TABLE_DEPTH)) begin
              res_status_nxt = pjt_pkg::STATUS_FULL;
            end else begin
              wr_en             = 1'b1;
              wr_addr           = count_r[IDX_W-1:0];
              wr_data.pid       = pid_r;
              wr_data.job       = job_r;
              wr_data.run_state = pjt_pkg::RUN_RUNNING;
              res_pos_nxt       = pjt_pkg::POS_W'(count_r);
              res_pid_nxt       = pid_r;
              res_job_nxt       = job_r;
              res_st_nxt        = pjt_pkg::RUN_RUNNING;
              count_nxt         = count_r + CNT_W'(1);
            end
          end
          pjt_pkg::KIND_REMOVE: begin
            if (hit_r) begin
              res_found_nxt = 1'b1;
              res_pos_nxt   = pjt_pkg::POS_W'(idx_r);
              res_pid_nxt   = ent_r.pid;
              res_job_nxt   = ent_r.job;
              res_st_nxt    = ent_r.run_state;
              count_nxt     = count_r - CNT_W'(1);
              scan_nxt      = CNT_W'(idx_r) + CNT_W'(1);
              chk_vld_nxt   = 1'b0;
              state_nxt     = pjt_pkg::S_SHIFT;
            end else begin
              res_status_nxt = pjt_pkg::STATUS_ABSENT;
            end
          end
          pjt_pkg::KIND_SET: begin
            if (hit_r) begin
              wr_en             = 1'b1;
              wr_addr           = idx_r;
              wr_data           = ent_r;
              wr_data.run_state = nst_r;
              res_found_nxt     = 1'b1;
              res_pos_nxt       = pjt_pkg::POS_W'(idx_r);
              res_pid_nxt       = ent_r.pid;
              res_job_nxt       = ent_r.job;
              res_st_nxt        = nst_r;
            end else begin
              res_status_nxt = pjt_pkg::STATUS_ABSENT;
            end
          end
          pjt_pkg::KIND_LK_PID, pjt_pkg::KIND_LK_JOB: begin
            if (hit_r) begin
              res_found_nxt = 1'b1;
              res_pos_nxt   = pjt_pkg::POS_W'(idx_r);
              res_pid_nxt   = ent_r.pid;
              res_job_nxt   = ent_r.job;
              res_st_nxt    = ent_r.run_state;
            end else begin
              res_status_nxt = pjt_pkg::STATUS_ABSENT;
            end
          end
          default: begin
          end
        endcase
      end

      // The count is already decremented here, so the last old entry sits at count_r.
      pjt_pkg::S_SHIFT: begin
        if (chk_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = chk_idx_r - IDX_W'(1);
          wr_data = rd_data_r;
        end
        if (scan_r <= count_r) begin
          chk_idx_nxt = scan_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
          scan_nxt    = scan_r + CNT_W'(1);
        end else begin
          chk_vld_nxt = 1'b0;
          state_nxt   = pjt_pkg::S_DONE;
        end
      end

      pjt_pkg::S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{pjt_pkg::OUT_PAD_W{1'b0}}, pjt_pkg::COUNT_W'(count_r),
                            res_st_r, res_job_r, res_pid_r, res_pos_r};
          out_tuser_nxt  = {res_found_r, res_status_r};
          state_nxt      = pjt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pjt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pjt_pkg::S_IDLE;
      count_r      <= '0;
      chk_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      chk_vld_r    <= chk_vld_nxt;
      hit_r        <= hit_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pid_r        <= pid_nxt;
    job_r        <= job_nxt;
    nst_r        <= nst_nxt;
    scan_r       <= scan_nxt;
    chk_idx_r    <= chk_idx_nxt;
    idx_r        <= idx_nxt;
    ent_r        <= ent_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_pos_r    <= res_pos_nxt;
    res_pid_r    <= res_pid_nxt;
    res_job_r    <= res_job_nxt;
    res_st_r     <= res_st_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

endmodule

### design/pjt_checker.sv
module pjt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pjt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [pjt_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pjt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [pjt_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready stayed high after a request was taken");

  // A full report only comes with a full table and no match.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == pjt_pkg::STATUS_FULL) |->
      (out_tdata[48:44] == pjt_pkg::COUNT_W'(pjt_pkg::TABLE_DEPTH)) && !out_tuser[2])
    else $error("table full reported with a wrong count or a match");

  // A match is never reported together with a not-found or full status.
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |->
      (out_tuser[1:0] == pjt_pkg::STATUS_OK) || (out_tuser[1:0] == pjt_pkg::STATUS_PRESENT))
    else $error("found flag with a failing status");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind process_job_table pjt_checker u_pjt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pjt_pkg::*;

  // Kinds above the last defined one do nothing but report the entry count.
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  localparam logic [RST_W-1:0] RUN_FINISHED  = 2'd1;
  localparam logic [RST_W-1:0] RUN_SUSPENDED = 2'd2;
  localparam logic [RST_W-1:0] RUN_KILLED    = 2'd3;

  localparam int PID_POOL_N  = 24;
  localparam int JOB_POOL_N  = 10;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 125;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  pid;
    logic [JOB_W-1:0]  job;
    logic [RST_W-1:0]  nst;
  } job_req_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [POS_W-1:0]   pos;
    logic [PID_W-1:0]   pid;
    logic [JOB_W-1:0]   job;
    logic [RST_W-1:0]   run_state;
    logic [COUNT_W-1:0] count;
  } job_resp_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  process_job_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  job_req_t  pending_req[$];
  job_resp_t expected_resp[$];
  int        err_count = 0;

  logic [PID_W-1:0] pid_pool [PID_POOL_N];
  logic [JOB_W-1:0] job_pool [JOB_POOL_N];

  // Shadow copy of the job table.
  logic [PID_W-1:0] tbl_pid   [TABLE_DEPTH];
  logic [JOB_W-1:0] tbl_job   [TABLE_DEPTH];
  logic [RST_W-1:0] tbl_state [TABLE_DEPTH];
  int               tbl_count = 0;

  function automatic int find_by_pid(logic [PID_W-1:0] p);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_pid[i] == p) return i;
    return -1;
  endfunction

  function automatic int find_by_job(logic [JOB_W-1:0] j);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_job[i] == j) return i;
    return -1;
  endfunction

  function automatic job_resp_t predict_job_table(job_req_t r);
    job_resp_t res;
    int        hit;
    res = '{default: '0};
    res.status = STATUS_OK;
    hit = -1;
    case (r.kind)
      KIND_ADD: begin
        hit = find_by_pid(r.pid);
        if (hit >= 0) begin
          res.status = STATUS_PRESENT;
          res.found  = 1'b1;
        end else if (tbl_count >= TABLE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          hit = tbl_count;
          tbl_pid[hit]   = r.pid;
          tbl_job[hit]   = r.job;
          tbl_state[hit] = RUN_RUNNING;
          tbl_count++;
        end
      end
      KIND_REMOVE: begin
        hit = find_by_pid(r.pid);
        if (hit >= 0) begin
          // The result shows the entry as it was before it left the table.
          res.found     = 1'b1;
          res.pos       = POS_W'(hit);
          res.pid       = tbl_pid[hit];
          res.job       = tbl_job[hit];
          res.run_state = tbl_state[hit];
          for (int i = hit + 1; i < tbl_count; i++) begin
            tbl_pid[i-1]   = tbl_pid[i];
            tbl_job[i-1]   = tbl_job[i];
            tbl_state[i-1] = tbl_state[i];
          end
          tbl_count--;
          hit = -1;
        end else begin
          res.status = STATUS_ABSENT;
        end
      end
      KIND_SET: begin
        hit = find_by_pid(r.pid);
        if (hit >= 0) begin
          res.found = 1'b1;
          tbl_state[hit] = r.nst;
        end else begin
          res.status = STATUS_ABSENT;
        end
      end
      KIND_LK_PID: begin
        hit = find_by_pid(r.pid);
        if (hit >= 0) res.found = 1'b1;
        else res.status = STATUS_ABSENT;
      end
      KIND_LK_JOB: begin
        hit = find_by_job(r.job);
        if (hit >= 0) res.found = 1'b1;
        else res.status = STATUS_ABSENT;
      end
      default: ;
    endcase
    if (hit >= 0) begin
      res.pos       = POS_W'(hit);
      res.pid       = tbl_pid[hit];
      res.job       = tbl_job[hit];
      res.run_state = tbl_state[hit];
    end
    res.count = COUNT_W'(tbl_count);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic void queue_req(logic [KIND_W-1:0] kind, logic [PID_W-1:0] pid,
                                    logic [JOB_W-1:0] job, logic [RST_W-1:0] nst);
    job_req_t r;
    r.kind = kind;
    r.pid  = pid;
    r.job  = job;
    r.nst  = nst;
    pending_req.push_back(r);
  endfunction

  // Driver: bursts of back-to-back transactions separated by random gaps.
  int       burst_left = 1;
  int       gap_left   = 0;
  logic     in_fire;
  job_req_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      in_fire = in_tvalid && in_tready;
      if (in_fire) expected_resp.push_back(predict_job_table(pending_req.pop_front()));
      if (!in_tvalid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_req.size() != 0) begin
          next_req = pending_req[0];
          in_tvalid <= 1'b1;
          in_tdata  <= {next_req.nst, next_req.job, next_req.pid};
          in_tuser  <= next_req.kind;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and drives a changing stall pattern.
  int        rdy_mode   = 0;
  int        rdy_period = 1;
  int        rdy_duty   = 1;
  int        rdy_phase  = 0;
  int        rdy_epoch  = 0;
  job_resp_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_resp.size() == 0) begin
          report_mismatch("unexpected result", 64'({out_tuser, out_tdata}), '0);
        end else begin
          want = expected_resp.pop_front();
          check_field("status",      64'(out_tuser[1:0]),   64'(want.status));
          check_field("found",       64'(out_tuser[2]),     64'(want.found));
          check_field("position",    64'(out_tdata[3:0]),   64'(want.pos));
          check_field("pid_out",     64'(out_tdata[25:4]),  64'(want.pid));
          check_field("job_out",     64'(out_tdata[41:26]), 64'(want.job));
          check_field("state_out",   64'(out_tdata[43:42]), 64'(want.run_state));
          check_field("entry_count", 64'(out_tdata[48:44]), 64'(want.count));
          check_field("padding",     64'(out_tdata[55:49]), '0);
        end
      end
      rdy_epoch++;
      if (rdy_epoch >= 300) begin
        rdy_epoch = 0;
        rdy_mode  = $urandom_range(0, 2);
        if (rdy_mode == 0) begin
          rdy_period = 1;
          rdy_duty   = 1;
        end else begin
          rdy_period = $urandom_range(2, 16);
          rdy_duty   = $urandom_range(1, rdy_period - 1);
        end
        rdy_phase = 0;
      end
      rdy_phase = (rdy_phase + 1) % rdy_period;
      if (rdy_mode == 1) out_tready <= 1'($urandom_range(0, 1));
      else out_tready <= (rdy_phase < rdy_duty);
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int                add_pct;
    int                pick;
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  pid;
    logic [JOB_W-1:0]  job;

    pid_pool[0] = '0;
    pid_pool[1] = '1;
    for (int i = 2; i < PID_POOL_N; i++) pid_pool[i] = PID_W'($urandom);
    job_pool[0] = '0;
    job_pool[1] = '1;
    for (int i = 2; i < JOB_POOL_N; i++) job_pool[i] = JOB_W'($urandom);

    // Requests against an empty table, including an unused kind.
    queue_req(KIND_LK_PID, pid_pool[0], job_pool[1], RUN_RUNNING);
    queue_req(KIND_LK_JOB, pid_pool[1], job_pool[0], RUN_KILLED);
    queue_req(KIND_REMOVE, pid_pool[1], job_pool[1], RUN_KILLED);
    queue_req(KIND_SET,    pid_pool[2], job_pool[2], RUN_KILLED);
    queue_req(KIND_UNUSED_HI, '1, '1, RUN_KILLED);
    // Fill the table; job numbers repeat so lookups by job see duplicates.
    for (int i = 0; i < TABLE_DEPTH; i++)
      queue_req(KIND_ADD, pid_pool[i], job_pool[i % JOB_POOL_N], 2'($urandom));
    queue_req(KIND_ADD,    pid_pool[TABLE_DEPTH], job_pool[2], RUN_RUNNING);
    queue_req(KIND_ADD,    pid_pool[5], job_pool[7], RUN_KILLED);
    queue_req(KIND_LK_JOB, pid_pool[20], job_pool[3], RUN_SUSPENDED);
    queue_req(KIND_REMOVE, pid_pool[0], job_pool[4], RUN_FINISHED);
    queue_req(KIND_SET,    pid_pool[15], job_pool[5], RUN_KILLED);
    queue_req(KIND_LK_PID, pid_pool[15], job_pool[6], RUN_RUNNING);

    // Each phase leans toward filling or draining the table.
    for (int ph = 0; ph < PHASES; ph++) begin
      add_pct = $urandom_range(10, 70);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        else if (pick < 3 + add_pct) kind = KIND_ADD;
        else begin
          case (pick % 4)
            0: kind = KIND_REMOVE;
            1: kind = KIND_SET;
            2: kind = KIND_LK_PID;
            default: kind = KIND_LK_JOB;
          endcase
        end
        // Adds stay inside the pool so every entry can be removed again later.
        if (kind == KIND_ADD || $urandom_range(0, 9) != 0)
          pid = pid_pool[$urandom_range(0, PID_POOL_N - 1)];
        else
          pid = PID_W'($urandom);
        if ($urandom_range(0, 4) != 0) job = job_pool[$urandom_range(0, JOB_POOL_N - 1)];
        else job = JOB_W'($urandom);
        queue_req(kind, pid, job, RST_W'($urandom_range(RUN_RUNNING, RUN_KILLED)));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_req.size() != 0 || expected_resp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
